/* rtl/vps_pkg.sv */
package vps_pkg;

    // Configuration write port
    localparam int unsigned CFG_DATA_W = 22;
    localparam int unsigned CFG_IDX_W  = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRICTION      = 3'd0,
        CFG_BOUNCE        = 3'd1,
        CFG_GRAVITY       = 3'd2,
        CFG_MIN_SPEED     = 3'd3,
        CFG_SCREEN_LEFT   = 3'd4,
        CFG_SCREEN_TOP    = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [16:0]        RST_FRICTION      = 17'd64880;
    localparam logic [16:0]        RST_BOUNCE        = 17'd32768;
    localparam logic signed [21:0] RST_GRAVITY       = 22'sd32768;
    localparam logic [20:0]        RST_MIN_SPEED     = 21'd6554;
    localparam logic signed [15:0] RST_SCREEN_LEFT   = 16'sd0;
    localparam logic signed [15:0] RST_SCREEN_TOP    = 16'sd0;
    localparam logic [15:0]        RST_SCREEN_WIDTH  = 16'd1920;
    localparam logic [15:0]        RST_SCREEN_HEIGHT = 16'd1040;

    // Unity factor in Q1.16
    localparam logic [16:0] FACTOR_ONE = 17'd65536;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] old_x;
        logic signed [31:0] old_y;
        logic        [23:0] radius;
        logic               pinned;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_old_x;
        logic signed [31:0] new_old_y;
        logic        [30:0] impact;
    } t_out_item;

endpackage

/* rtl/verlet_particle_step.sv */
// Channel  | Signals                                 | Moves
// ---------+-----------------------------------------+------------------------------
// in       | i_in_valid, o_in_ready, i_in_data       | one particle per transaction
// out      | o_out_valid, i_out_ready, o_out_data    | one updated particle
// cfg      | i_cfg_wr_en, i_cfg_idx, i_cfg_wdata     | one register write, no wait
//
// Six register stages; one particle enters per cycle while o_in_ready is high. The accepting
// edge loads the first stage; the result then moves through the stages in order, is presented
// from the last stage register and is taken from there when the output is not stalled.
// Stage depth is set by the friction multiply, the squared-speed multiplies and
// the bounce multiply, each in a stage of its own, and the wall compare chain.
// Synchronous active-low reset clears the stage valid bits and loads the
// configuration registers with their defaults.
// A stall at the output backs up stage by stage; empty stages still fill, and
// o_in_ready falls only when every stage holds a particle.
module verlet_particle_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  vps_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [vps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  vps_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output vps_pkg::t_out_item                 o_out_data
);
    import vps_pkg::*;

    localparam int unsigned NUM_STG = 6;

    localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
    localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[31:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [16:0] r_friction;
    logic        [16:0] r_bounce;
    logic signed [21:0] r_gravity;
    logic        [20:0] r_min_speed;
    logic signed [15:0] r_screen_left;
    logic signed [15:0] r_screen_top;
    logic        [15:0] r_screen_width;
    logic        [15:0] r_screen_height;

    // Decode register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_friction      <= RST_FRICTION;
            r_bounce        <= RST_BOUNCE;
            r_gravity       <= RST_GRAVITY;
            r_min_speed     <= RST_MIN_SPEED;
            r_screen_left   <= RST_SCREEN_LEFT;
            r_screen_top    <= RST_SCREEN_TOP;
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FRICTION:      r_friction      <= i_cfg_wdata[16:0];
                CFG_BOUNCE:        r_bounce        <= i_cfg_wdata[16:0];
                CFG_GRAVITY:       r_gravity       <= signed'(i_cfg_wdata[21:0]);
                CFG_MIN_SPEED:     r_min_speed     <= i_cfg_wdata[20:0];
                CFG_SCREEN_LEFT:   r_screen_left   <= signed'(i_cfg_wdata[15:0]);
                CFG_SCREEN_TOP:    r_screen_top    <= signed'(i_cfg_wdata[15:0]);
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata[15:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Clamp factors to one and form the wall positions in Q20.16
    logic        [16:0] fr_c;
    logic        [16:0] bo_c;
    logic signed [17:0] fr_s;
    logic signed [17:0] bo_s;
    logic signed [17:0] top_i;
    logic signed [17:0] bot_i;
    logic signed [17:0] lef_i;
    logic signed [17:0] rig_i;
    logic signed [35:0] top_q;
    logic signed [35:0] bot_q;
    logic signed [35:0] lef_q;
    logic signed [35:0] rig_q;

    always_comb begin
        fr_c  = (r_friction > FACTOR_ONE) ? FACTOR_ONE : r_friction;
        bo_c  = (r_bounce > FACTOR_ONE) ? FACTOR_ONE : r_bounce;
        fr_s  = signed'({1'b0, fr_c});
        bo_s  = signed'({1'b0, bo_c});
        top_i = signed'({{2{r_screen_top[15]}}, r_screen_top});
        lef_i = signed'({{2{r_screen_left[15]}}, r_screen_left});
        bot_i = top_i + signed'({2'b00, r_screen_height});
        rig_i = lef_i + signed'({2'b00, r_screen_width});
        top_q = signed'({{2{top_i[17]}}, top_i, 16'h0000});
        bot_q = signed'({{2{bot_i[17]}}, bot_i, 16'h0000});
        lef_q = signed'({{2{lef_i[17]}}, lef_i, 16'h0000});
        rig_q = signed'({{2{rig_i[17]}}, rig_i, 16'h0000});
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance enables
    // ------------------------------------------------------------------
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] stg_en;

    // Let a stage load when it is empty or its content moves on
    always_comb begin
        stg_en[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
        n_vld = {r_vld[NUM_STG-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[NUM_STG-1];

    // ------------------------------------------------------------------
    // Stage 1: position differences times friction
    // ------------------------------------------------------------------
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [50:0] n_s1_prodx;
    logic signed [50:0] n_s1_prody;

    logic signed [50:0] r_s1_prodx;
    logic signed [50:0] r_s1_prody;
    logic signed [31:0] r_s1_px;
    logic signed [31:0] r_s1_py;
    logic signed [31:0] r_s1_ox;
    logic signed [31:0] r_s1_oy;
    logic        [23:0] r_s1_r;
    logic               r_s1_pin;

    always_comb begin
        dx = signed'({i_in_data.pos_x[31], i_in_data.pos_x})
           - signed'({i_in_data.old_x[31], i_in_data.old_x});
        dy = signed'({i_in_data.pos_y[31], i_in_data.pos_y})
           - signed'({i_in_data.old_y[31], i_in_data.old_y});
        n_s1_prodx = dx * fr_s;
        n_s1_prody = dy * fr_s;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_prodx <= n_s1_prodx;
            r_s1_prody <= n_s1_prody;
            r_s1_px    <= i_in_data.pos_x;
            r_s1_py    <= i_in_data.pos_y;
            r_s1_ox    <= i_in_data.old_x;
            r_s1_oy    <= i_in_data.old_y;
            r_s1_r     <= i_in_data.radius;
            r_s1_pin   <= i_in_data.pinned;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round velocity, square its magnitudes
    // ------------------------------------------------------------------
    logic signed [50:0] rnd_x;
    logic signed [50:0] rnd_y;
    logic signed [33:0] n_s2_vx;
    logic signed [33:0] n_s2_vy;
    logic signed [33:0] abs_x;
    logic signed [33:0] abs_y;
    logic        [32:0] ax;
    logic        [32:0] ay;
    logic        [41:0] n_s2_sqx;
    logic        [41:0] n_s2_sqy;
    logic        [41:0] n_s2_ms2;
    logic               n_s2_small;

    logic signed [33:0] r_s2_vx;
    logic signed [33:0] r_s2_vy;
    logic        [41:0] r_s2_sqx;
    logic        [41:0] r_s2_sqy;
    logic        [41:0] r_s2_ms2;
    logic               r_s2_small;
    logic signed [31:0] r_s2_px;
    logic signed [31:0] r_s2_py;
    logic signed [31:0] r_s2_ox;
    logic signed [31:0] r_s2_oy;
    logic        [23:0] r_s2_r;
    logic               r_s2_pin;

    always_comb begin
        rnd_x      = r_s1_prodx + 51'sd32768;
        rnd_y      = r_s1_prody + 51'sd32768;
        n_s2_vx    = rnd_x[49:16];
        n_s2_vy    = rnd_y[49:16];
        abs_x      = n_s2_vx[33] ? -n_s2_vx : n_s2_vx;
        abs_y      = n_s2_vy[33] ? -n_s2_vy : n_s2_vy;
        ax         = abs_x[32:0];
        ay         = abs_y[32:0];
        // Squares only matter when both magnitudes are below min_speed
        n_s2_sqx   = ax[20:0] * ax[20:0];
        n_s2_sqy   = ay[20:0] * ay[20:0];
        n_s2_ms2   = r_min_speed * r_min_speed;
        n_s2_small = (ax < {12'h000, r_min_speed}) && (ay < {12'h000, r_min_speed});
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_vx    <= n_s2_vx;
            r_s2_vy    <= n_s2_vy;
            r_s2_sqx   <= n_s2_sqx;
            r_s2_sqy   <= n_s2_sqy;
            r_s2_ms2   <= n_s2_ms2;
            r_s2_small <= n_s2_small;
            r_s2_px    <= r_s1_px;
            r_s2_py    <= r_s1_py;
            r_s2_ox    <= r_s1_ox;
            r_s2_oy    <= r_s1_oy;
            r_s2_r     <= r_s1_r;
            r_s2_pin   <= r_s1_pin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: drop velocity below the minimum speed
    // ------------------------------------------------------------------
    logic               still;
    logic signed [33:0] n_s3_vx;
    logic signed [33:0] n_s3_vy;

    logic signed [33:0] r_s3_vx;
    logic signed [33:0] r_s3_vy;
    logic signed [31:0] r_s3_px;
    logic signed [31:0] r_s3_py;
    logic signed [31:0] r_s3_ox;
    logic signed [31:0] r_s3_oy;
    logic        [23:0] r_s3_r;
    logic               r_s3_pin;

    always_comb begin
        still   = r_s2_small
               && (({1'b0, r_s2_sqx} + {1'b0, r_s2_sqy}) < {1'b0, r_s2_ms2});
        n_s3_vx = still ? '0 : r_s2_vx;
        n_s3_vy = still ? '0 : r_s2_vy;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_vx  <= n_s3_vx;
            r_s3_vy  <= n_s3_vy;
            r_s3_px  <= r_s2_px;
            r_s3_py  <= r_s2_py;
            r_s3_ox  <= r_s2_ox;
            r_s3_oy  <= r_s2_oy;
            r_s3_r   <= r_s2_r;
            r_s3_pin <= r_s2_pin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: move, bounce products, clamped wall positions
    // ------------------------------------------------------------------
    logic signed [35:0] s3_r36;
    logic signed [35:0] n_s4_nx_sum;
    logic signed [35:0] n_s4_ny_sum;
    logic signed [51:0] n_s4_bpx;
    logic signed [51:0] n_s4_bpy;

    logic signed [31:0] r_s4_nx0;
    logic signed [31:0] r_s4_ny0;
    logic signed [51:0] r_s4_bpx;
    logic signed [51:0] r_s4_bpy;
    logic signed [31:0] r_s4_ebot;
    logic signed [31:0] r_s4_etop;
    logic signed [31:0] r_s4_erig;
    logic signed [31:0] r_s4_elef;
    logic signed [33:0] r_s4_vx;
    logic signed [33:0] r_s4_vy;
    logic        [23:0] r_s4_r;
    logic signed [31:0] r_s4_px;
    logic signed [31:0] r_s4_py;
    logic signed [31:0] r_s4_ox;
    logic signed [31:0] r_s4_oy;
    logic               r_s4_pin;

    always_comb begin
        s3_r36      = signed'({12'h000, r_s3_r});
        n_s4_nx_sum = signed'({{4{r_s3_px[31]}}, r_s3_px})
                    + signed'({{2{r_s3_vx[33]}}, r_s3_vx});
        n_s4_ny_sum = signed'({{4{r_s3_py[31]}}, r_s3_py})
                    + signed'({{2{r_s3_vy[33]}}, r_s3_vy})
                    + signed'({{14{r_gravity[21]}}, r_gravity});
        n_s4_bpx    = r_s3_vx * bo_s;
        n_s4_bpy    = r_s3_vy * bo_s;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_nx0  <= sat32(n_s4_nx_sum);
            r_s4_ny0  <= sat32(n_s4_ny_sum);
            r_s4_bpx  <= n_s4_bpx;
            r_s4_bpy  <= n_s4_bpy;
            r_s4_ebot <= sat32(bot_q - s3_r36);
            r_s4_etop <= sat32(top_q + s3_r36);
            r_s4_erig <= sat32(rig_q - s3_r36);
            r_s4_elef <= sat32(lef_q + s3_r36);
            r_s4_vx   <= r_s3_vx;
            r_s4_vy   <= r_s3_vy;
            r_s4_r    <= r_s3_r;
            r_s4_px   <= r_s3_px;
            r_s4_py   <= r_s3_py;
            r_s4_ox   <= r_s3_ox;
            r_s4_oy   <= r_s3_oy;
            r_s4_pin  <= r_s3_pin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: wall tests in order floor, ceiling, right, left
    // ------------------------------------------------------------------
    logic signed [35:0] s4_r36;
    logic               hit_bot;
    logic               hit_top;
    logic               hit_rig;
    logic               hit_lef;
    logic signed [31:0] ny1;
    logic signed [31:0] nx1;
    logic signed [31:0] n_s5_ny;
    logic signed [31:0] n_s5_nx;
    logic signed [51:0] brnd_x;
    logic signed [51:0] brnd_y;
    logic signed [33:0] neg_vx;
    logic signed [33:0] neg_vy;
    logic        [32:0] imp_bot;
    logic        [32:0] imp_rig;
    logic        [32:0] n_s5_iy;
    logic        [32:0] n_s5_ix;

    logic signed [31:0] r_s5_nx;
    logic signed [31:0] r_s5_ny;
    logic               r_s5_xhit;
    logic               r_s5_yhit;
    logic signed [33:0] r_s5_bx;
    logic signed [33:0] r_s5_by;
    logic        [32:0] r_s5_ix;
    logic        [32:0] r_s5_iy;
    logic signed [31:0] r_s5_px;
    logic signed [31:0] r_s5_py;
    logic signed [31:0] r_s5_ox;
    logic signed [31:0] r_s5_oy;
    logic               r_s5_pin;

    always_comb begin
        s4_r36  = signed'({12'h000, r_s4_r});
        // Floor, then ceiling on the possibly clamped y
        hit_bot = (signed'({{4{r_s4_ny0[31]}}, r_s4_ny0}) + s4_r36) > bot_q;
        ny1     = hit_bot ? r_s4_ebot : r_s4_ny0;
        hit_top = (signed'({{4{ny1[31]}}, ny1}) - s4_r36) < top_q;
        n_s5_ny = hit_top ? r_s4_etop : ny1;
        // Right, then left on the possibly clamped x
        hit_rig = (signed'({{4{r_s4_nx0[31]}}, r_s4_nx0}) + s4_r36) > rig_q;
        nx1     = hit_rig ? r_s4_erig : r_s4_nx0;
        hit_lef = (signed'({{4{nx1[31]}}, nx1}) - s4_r36) < lef_q;
        n_s5_nx = hit_lef ? r_s4_elef : nx1;

        // Round the bounce products
        brnd_x  = r_s4_bpx + 52'sd32768;
        brnd_y  = r_s4_bpy + 52'sd32768;

        // Largest incoming speed per axis, never below zero
        neg_vy  = -r_s4_vy;
        neg_vx  = -r_s4_vx;
        imp_bot = (hit_bot && !r_s4_vy[33]) ? r_s4_vy[32:0] : '0;
        n_s5_iy = (hit_top && !neg_vy[33] && (neg_vy[32:0] > imp_bot))
                ? neg_vy[32:0] : imp_bot;
        imp_rig = (hit_rig && !r_s4_vx[33]) ? r_s4_vx[32:0] : '0;
        n_s5_ix = (hit_lef && !neg_vx[33] && (neg_vx[32:0] > imp_rig))
                ? neg_vx[32:0] : imp_rig;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s5_nx   <= n_s5_nx;
            r_s5_ny   <= n_s5_ny;
            r_s5_xhit <= hit_rig || hit_lef;
            r_s5_yhit <= hit_bot || hit_top;
            r_s5_bx   <= brnd_x[49:16];
            r_s5_by   <= brnd_y[49:16];
            r_s5_ix   <= n_s5_ix;
            r_s5_iy   <= n_s5_iy;
            r_s5_px   <= r_s4_px;
            r_s5_py   <= r_s4_py;
            r_s5_ox   <= r_s4_ox;
            r_s5_oy   <= r_s4_oy;
            r_s5_pin  <= r_s4_pin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: reflected old position, impact, pinned bypass
    // ------------------------------------------------------------------
    logic signed [35:0] nox_sum;
    logic signed [35:0] noy_sum;
    logic        [32:0] imp_max;
    t_out_item          n_out;
    t_out_item          r_out;

    always_comb begin
        nox_sum = signed'({{4{r_s5_nx[31]}}, r_s5_nx})
                - signed'({{2{r_s5_bx[33]}}, r_s5_bx});
        noy_sum = signed'({{4{r_s5_ny[31]}}, r_s5_ny})
                - signed'({{2{r_s5_by[33]}}, r_s5_by});
        imp_max = (r_s5_ix > r_s5_iy) ? r_s5_ix : r_s5_iy;
        if (r_s5_pin) begin
            n_out.new_x     = r_s5_px;
            n_out.new_y     = r_s5_py;
            n_out.new_old_x = r_s5_ox;
            n_out.new_old_y = r_s5_oy;
            n_out.impact    = '0;
        end else begin
            n_out.new_x     = r_s5_nx;
            n_out.new_y     = r_s5_ny;
            n_out.new_old_x = r_s5_xhit ? sat32(nox_sum) : r_s5_px;
            n_out.new_old_y = r_s5_yhit ? sat32(noy_sum) : r_s5_py;
            n_out.impact    = (imp_max > {2'b00, 31'h7FFFFFFF})
                            ? 31'h7FFFFFFF : imp_max[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_when_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_pinned_no_impact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_en[5] && r_vld[4] && r_s5_pin) |=> (r_out.impact == '0))
        else $error("pinned particle reported an impact");

    a_no_hit_keeps_old_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_en[5] && r_vld[4] && !r_s5_pin && !r_s5_yhit)
        |=> (r_out.new_old_y == $past(r_s5_py)))
        else $error("old y changed without a floor or ceiling hit");

endmodule
